>>> sv/cor_pkg.sv
package cor_pkg;

  localparam int SCREEN_COLS_DEF = 320;
  localparam int SCREEN_ROWS_DEF = 200;
  localparam int MAX_RADIUS_DEF  = 90;

  localparam int ADDR_W  = 16;
  localparam int COORD_W = 12;
  localparam int RSQ_W   = 14;
  localparam int ROOT_W  = 7;
  localparam int STEP_W  = 6;

  localparam logic [RSQ_W-1:0] SQRT_BIT_FIRST = 14'h1000;

  typedef struct packed {
    logic [8:0]        cx;
    logic [7:0]        cy;
    logic [ROOT_W-1:0] a;
    logic [ROOT_W-1:0] b;
    logic              neg_x;
    logic              neg_y;
  } pt_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              on;
  } pt_res_t;

endpackage

>>> sv/cor_isqrt.sv
module cor_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] value,
  output logic        done,
  output logic [6:0]  root
);
  import cor_pkg::*;

  logic [RSQ_W-1:0] v;
  logic [RSQ_W-1:0] res;
  logic [RSQ_W-1:0] bitm;
  logic             busy;
  logic [RSQ_W:0]   sum;

  // bit-pair restoring square root, one result bit per cycle
  assign sum  = {1'b0, res} + {1'b0, bitm};
  assign root = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bitm == RSQ_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bitm == RSQ_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      res  <= '0;
      bitm <= SQRT_BIT_FIRST;
    end else if (busy) begin
      if ({1'b0, v} >= sum) begin
        v   <= v - sum[RSQ_W-1:0];
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

>>> sv/cor_point.sv
module cor_point #(
  parameter int SCREEN_COLS = cor_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = cor_pkg::SCREEN_ROWS_DEF
) (
  input  cor_pkg::pt_req_t req,
  output cor_pkg::pt_res_t res
);
  import cor_pkg::*;

  localparam logic [10:0] COLS_C = 11'(SCREEN_COLS);
  localparam logic [10:0] ROWS_C = 11'(SCREEN_ROWS);

  logic [COORD_W-1:0] xs;
  logic [COORD_W-1:0] ys;
  logic               on_x;
  logic               on_y;
  logic [20:0]        row_base;
  logic [20:0]        full_addr;

  assign xs = req.neg_x ? (COORD_W'(req.cx) - COORD_W'(req.a))
                        : (COORD_W'(req.cx) + COORD_W'(req.a));
  assign ys = req.neg_y ? (COORD_W'(req.cy) - COORD_W'(req.b))
                        : (COORD_W'(req.cy) + COORD_W'(req.b));

  // top bit set means negative
  assign on_x = !xs[COORD_W-1] && (xs[10:0] < COLS_C);
  assign on_y = !ys[COORD_W-1] && (ys[10:0] < ROWS_C);

  assign row_base  = {11'b0, ys[9:0]} * {10'b0, COLS_C};
  assign full_addr = row_base + {10'b0, xs[10:0]};

  assign res.on   = on_x && on_y;
  assign res.addr = res.on ? full_addr[ADDR_W-1:0] : '0;

endmodule

>>> sv/circle_outline_rasterizer_top.sv
// Circle outline rasteriser: one request in, one item per row offset out.
// Each step: set up, then the shared square-root unit (seven root bits, then
// done), then the point address unit (one of the eight symmetric points a cycle),
// then the item is held until the receiver takes it.
// A circle has n steps (n <= 64); ready only when idle.
// rst (synchronous) clears the sequencer and the output valid.
module circle_outline_rasterizer_top #(
  parameter int SCREEN_COLS = cor_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = cor_pkg::SCREEN_ROWS_DEF,
  parameter int MAX_RADIUS  = cor_pkg::MAX_RADIUS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // centre column, centre row, radius, color
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,  // addr_right_down, addr_left_down, addr_right_up,
                                      // addr_left_up, addr_down_right, addr_down_left,
                                      // addr_up_right, addr_up_left, in_bounds_mask,
                                      // pixel_color
  output logic         m_axis_tlast   // last_step
);
  import cor_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_ROOT = 5'b00100,
    S_PTS  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam logic [ROOT_W-1:0] RMAX = ROOT_W'(MAX_RADIUS);

  state_t             state;
  logic [8:0]         cx;
  logic [7:0]         cy;
  logic [7:0]         col;
  logic [RSQ_W-1:0]   r2;
  logic [STEP_W-1:0]  dy;
  logic [ROOT_W-1:0]  dx;
  logic [2:0]         pt;
  logic [ADDR_W-1:0]  addr [8];
  logic [7:0]         mask;
  logic               last;

  logic [ROOT_W-1:0]  in_rad;
  logic [ROOT_W-1:0]  r_sat;
  logic [RSQ_W-1:0]   rsq;
  logic [11:0]        dy2;
  logic [RSQ_W-1:0]   dy2_ext;
  logic [RSQ_W-1:0]   rad_in;
  logic               sq_start;
  logic               sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic [ROOT_W-1:0]  dy_ext;
  logic [ROOT_W-1:0]  dy_inc;
  pt_req_t            preq;
  pt_res_t            pres;

  assign in_rad  = s_axis_tdata[23:17];
  assign r_sat   = (in_rad > RMAX) ? RMAX : in_rad;
  assign rsq     = {7'b0, r_sat} * {7'b0, r_sat};
  assign dy2     = {6'b0, dy} * {6'b0, dy};
  assign dy2_ext = {2'b0, dy2};
  assign rad_in  = (dy2_ext <= r2) ? (r2 - dy2_ext) : '0;
  assign sq_start = (state == S_SQ);

  cor_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (rad_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  // pt[2] swaps the roles of dx and dy, pt[0] mirrors x, pt[1] mirrors y
  assign dy_ext     = {1'b0, dy};
  assign dy_inc     = dy_ext + ROOT_W'(1);
  assign preq.cx    = cx;
  assign preq.cy    = cy;
  assign preq.a     = pt[2] ? dy_ext : dx;
  assign preq.b     = pt[2] ? dx : dy_ext;
  assign preq.neg_x = pt[0];
  assign preq.neg_y = pt[1];

  cor_point #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_point (
    .req (preq),
    .res (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            state <= S_PTS;
          end
        end
        S_PTS: begin
          if (pt == 3'd7) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= last ? S_IDLE : S_SQ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cx  <= s_axis_tdata[8:0];
          cy  <= s_axis_tdata[16:9];
          col <= s_axis_tdata[31:24];
          r2  <= rsq;
          dy  <= '0;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          dx   <= sq_root;
          pt   <= '0;
          mask <= '0;
        end
      end
      S_PTS: begin
        addr[pt]  <= pres.addr;
        mask[pt]  <= pres.on;
        pt        <= pt + 3'd1;
        if (pt == 3'd7) begin
          last <= (dy_inc >= dx) || (dy == '1);
        end
      end
      S_OUT: begin
        if (m_axis_tready && !last) begin
          dy <= dy + STEP_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {col, mask, addr[7], addr[6], addr[5], addr[4],
                          addr[3], addr[2], addr[1], addr[0]};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a step item is pending");

  a_continue: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> (state == S_SQ))
    else $error("sequencer left the circle before its last step");

  a_step_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (dy == '1) |-> m_axis_tlast)
    else $error("step cap reached without last_step");

  a_root_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_ROOT))
    else $error("square root finished outside the wait state");

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !mask[0] |-> (addr[0] == '0))
    else $error("off-screen point carries a nonzero address");

endmodule

>>> tb/sv/tb_circle_outline_rasterizer_top.sv
module tb_circle_outline_rasterizer_top;
  import cor_pkg::*;

  localparam int N_RANDOM     = 300;
  localparam int MAX_STEPS    = 64;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 2500;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 40;
  localparam int HOLD_AT      = 40;
  localparam int PAUSE_AT     = 150;

  // packed msb first so that the struct matches tdata bit for bit
  typedef struct packed {
    logic [7:0] color;
    logic [6:0] radius;
    logic [7:0] cen_row;
    logic [8:0] cen_col;
  } circle_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr [8];
    logic [7:0]        mask;
    logic [7:0]        colour;
    logic              last;
  } outline_row_t;

  typedef struct {
    circle_req_t  req;
    bit           gold_valid;
    outline_row_t gold;
  } directed_row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tlast;

  outline_row_t  outline_rows_due [$];
  outline_row_t  want;
  outline_row_t  no_gold;
  directed_row_t directed_tbl [17];
  int            fail_count = 0;
  int            sent_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_left = 0;
  bit            hold_req = 1'b0;
  int unsigned   cycle_count = 0;

  circle_outline_rasterizer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned s;
    s = 0;
    while ((s + 1) * (s + 1) <= v) s++;
    return s;
  endfunction

  function automatic void predict_outline(circle_req_t req);
    int r, dx, dy, steps, cx, cy;
    int px [8];
    int py [8];
    outline_row_t row;
    bit done;
    cx = int'(req.cen_col);
    cy = int'(req.cen_row);
    r = (int'(req.radius) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(req.radius);
    dy = 0;
    steps = 0;
    done = 1'b0;
    while (!done) begin
      dx = (dy * dy <= r * r) ? int'(floor_root(r * r - dy * dy)) : 0;
      px = '{cx + dx, cx - dx, cx + dx, cx - dx, cx + dy, cx - dy, cx + dy, cx - dy};
      py = '{cy + dy, cy + dy, cy - dy, cy - dy, cy + dx, cy + dx, cy - dx, cy - dx};
      row.mask = '0;
      for (int i = 0; i < 8; i++) begin
        if (px[i] >= 0 && px[i] < SCREEN_COLS_DEF && py[i] >= 0 && py[i] < SCREEN_ROWS_DEF) begin
          row.addr[i] = ADDR_W'(py[i] * SCREEN_COLS_DEF + px[i]);
          row.mask[i] = 1'b1;
        end else begin
          row.addr[i] = '0;
        end
      end
      row.colour = req.color;
      steps++;
      dy++;
      done = (dy >= dx) || (steps >= MAX_STEPS);
      row.last = done;
      outline_rows_due.push_back(row);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch %s: got %0d, want %0d", what, got, want_v);
  endtask

  // idling phases: receiver-heavy gaps, then sender-heavy, then none
  task automatic send_circle(input circle_req_t req, input bit gold_valid,
                             input outline_row_t gold);
    int phase;
    phase = sent_count * 3 / ($size(directed_tbl) + N_RANDOM);
    send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 71 : 0;
    recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 26 : 0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_count++;
    if (gold_valid)
      outline_rows_due.push_back(gold);
    else
      predict_outline(req);
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (outline_rows_due.size() == 0) begin
        report_mismatch("item with none due", 1, 0);
      end else begin
        want = outline_rows_due.pop_front();
        for (int i = 0; i < 8; i++)
          if (m_axis_tdata[16*i +: 16] !== want.addr[i])
            report_mismatch($sformatf("addr[%0d]", i), m_axis_tdata[16*i +: 16], want.addr[i]);
        if (m_axis_tdata[135:128] !== want.mask)
          report_mismatch("in_bounds_mask", m_axis_tdata[135:128], want.mask);
        if (m_axis_tdata[143:136] !== want.colour)
          report_mismatch("pixel_color", m_axis_tdata[143:136], want.colour);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_step", m_axis_tlast, want.last);
      end
    end
  end

  initial begin
    circle_req_t req;
    no_gold = '{'{default: 16'd0}, 8'h00, 8'h00, 1'b0};
    // req fields: color, radius, centre row, centre column
    directed_tbl = '{
      '{'{8'h5A, 7'd0, 8'd0, 9'd0}, 1'b1, '{'{default: 16'd0}, 8'hFF, 8'h5A, 1'b1}},
      '{'{8'hFF, 7'd0, 8'd199, 9'd319}, 1'b1,
        '{'{default: 16'd63999}, 8'hFF, 8'hFF, 1'b1}},
      '{'{8'h00, 7'd0, 8'd255, 9'd511}, 1'b1, '{'{default: 16'd0}, 8'h00, 8'h00, 1'b1}},
      '{'{8'hA5, 7'd1, 8'd0, 9'd0}, 1'b1,
        '{'{16'd1, 16'd0, 16'd1, 16'd0, 16'd320, 16'd320, 16'd0, 16'd0},
          8'h35, 8'hA5, 1'b1}},
      '{'{8'h3C, 7'd1, 8'd199, 9'd319}, 1'b1,
        '{'{16'd0, 16'd63998, 16'd0, 16'd63998, 16'd0, 16'd0, 16'd63679, 16'd63679},
          8'hCA, 8'h3C, 1'b1}},
      '{'{8'hFF, 7'd90, 8'd100, 9'd160}, 1'b0, no_gold},
      '{'{8'h00, 7'd127, 8'd100, 9'd160}, 1'b0, no_gold},
      '{'{8'h81, 7'd90, 8'd0, 9'd0}, 1'b0, no_gold},
      '{'{8'h7E, 7'd90, 8'd199, 9'd319}, 1'b0, no_gold},
      '{'{8'h11, 7'd64, 8'd0, 9'd319}, 1'b0, no_gold},
      '{'{8'h22, 7'd50, 8'd199, 9'd0}, 1'b0, no_gold},
      '{'{8'h33, 7'd2, 8'd50, 9'd100}, 1'b0, no_gold},
      '{'{8'h44, 7'd3, 8'd150, 9'd200}, 1'b0, no_gold},
      '{'{8'h55, 7'd127, 8'd128, 9'd256}, 1'b0, no_gold},
      '{'{8'h66, 7'd90, 8'd255, 9'd511}, 1'b0, no_gold},
      '{'{8'hAA, 7'd45, 8'd10, 9'd300}, 1'b0, no_gold},
      '{'{8'h99, 7'd10, 8'd200, 9'd320}, 1'b0, no_gold}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_tbl[n])
      send_circle(directed_tbl[n].req, directed_tbl[n].gold_valid, directed_tbl[n].gold);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == HOLD_AT) hold_req = 1'b1;
      if (k == PAUSE_AT) begin
        s_axis_tvalid <= 1'b0;
        wait (outline_rows_due.size() == 0);
        @(posedge clk);
      end
      req.cen_col = ($urandom_range(7) == 0) ? 9'($urandom_range(511)) :
                                                9'($urandom_range(319));
      req.cen_row = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
                                                8'($urandom_range(199));
      case ($urandom_range(3))
        0:       req.radius = 7'($urandom_range(4));
        3:       req.radius = 7'($urandom_range(127));
        default: req.radius = 7'($urandom_range(90));
      endcase
      req.color = 8'($urandom_range(255));
      send_circle(req, 1'b0, no_gold);
    end
    s_axis_tvalid <= 1'b0;

    wait (outline_rows_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
